// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion that is switched off while reset is asserted.
`define SF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SF_ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SF_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SF_ASSERT_ALW(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/sf_pkg.sv =====
`timescale 1ns / 1ps

package sf_pkg;

    // Store and table geometry.
    localparam int BUFFER_DEPTH     = 4096;
    localparam int ADDR_W           = $clog2(BUFFER_DEPTH);
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR_DEPTH        = SINE_TABLE_DEPTH / 4;
    localparam int QTR_W            = SINE_IDX_W - 2;

    // Field widths.
    localparam int SMP_W      = 16;
    localparam int MEAN_W     = 11;
    localparam int SWING_W    = 11;
    localparam int STEP_W     = 32;
    localparam int GAIN_W     = 15;
    localparam int PHASE_W    = 32;
    localparam int FRAC_W     = 15;
    localparam int SINE_MAG_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Arithmetic widths of the delay and mix paths.
    localparam int NUM_W   = MEAN_W + FRAC_W + 2;
    localparam int DLY_Q_W = NUM_W - FRAC_W - 1;
    localparam int PROD_W  = SMP_W + GAIN_W;
    localparam int SUM_W   = PROD_W + 2;

    // Register reset values.
    localparam logic [MEAN_W-1:0]  MEAN_RST  = MEAN_W'(48);
    localparam logic [SWING_W-1:0] SWING_RST = SWING_W'(38);
    localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(8948);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(29491);

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAN_DELAY  = 2'd0,
        CFG_DELAY_SWING = 2'd1,
        CFG_PHASE_STEP  = 2'd2,
        CFG_MIX_GAIN    = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINE,
        ST_DELAY,
        ST_READ,
        ST_PROD,
        ST_MIX
    } t_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic sine_en;
        logic dly_en;
        logic rd_en;
        logic prod_en;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic out_stall;
    } t_sts;

    // Quarter-wave sine magnitudes, both ends of the quadrant included.
    typedef logic [SINE_MAG_W-1:0] t_qsine [0:QTR_DEPTH];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Fixed-point Taylor series of sin over one quadrant, evaluated at elaboration.
    function automatic t_qsine f_build_qsine();
        t_qsine      tab;
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int m = 0; m <= QTR_DEPTH; m++) begin
            f    = 64'(m) << (30 - QTR_W);
            x    = (f * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if ((n & 1) == 1) begin
                    sum = (sum >= term) ? sum - term : 64'd0;
                end else begin
                    sum = sum + term;
                end
            end
            sum    = (sum + 64'd16384) >> 15;
            tab[m] = (sum > 64'd32767) ? SINE_MAG_W'(32767) : sum[SINE_MAG_W-1:0];
        end
        return tab;
    endfunction

    localparam t_qsine QSINE_TAB = f_build_qsine();

endpackage

// ===== rtl/core/sf_in_if.sv =====
`timescale 1ns / 1ps

// Input channel: one stereo sample pair per word.
interface sf_in_if;
    import sf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// ===== rtl/core/sf_out_if.sv =====
`timescale 1ns / 1ps

// Output channel: one flanged stereo pair per word.
interface sf_out_if;
    import sf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/core/sf_ctrl.sv =====
`timescale 1ns / 1ps

module sf_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  sf_pkg::t_sts i_sts,
    output sf_pkg::t_cmd o_cmd
);
    import sf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SINE;
                end
            end
            ST_SINE: begin
                o_cmd.sine_en = 1'b1;
                n_state       = ST_DELAY;
            end
            ST_DELAY: begin
                o_cmd.dly_en = 1'b1;
                n_state      = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_PROD;
            end
            ST_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state       = ST_MIX;
            end
            ST_MIX: begin
                // Hold here while the previous word still sits unread.
                if (!i_sts.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/sf_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sf_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sf_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [sf_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  logic signed [sf_pkg::SMP_W-1:0]        i_left_in,
    input  logic signed [sf_pkg::SMP_W-1:0]        i_right_in,
    input  sf_pkg::t_cmd                           i_cmd,
    output sf_pkg::t_sts                           o_sts,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [sf_pkg::SMP_W-1:0]        o_left_out,
    output logic signed [sf_pkg::SMP_W-1:0]        o_right_out
);
    import sf_pkg::*;

    // Configuration registers.
    logic [MEAN_W-1:0]  r_mean;
    logic [SWING_W-1:0] r_swing;
    logic [STEP_W-1:0]  r_step;
    logic [GAIN_W-1:0]  r_gain;

    // Delay line state.
    logic [SMP_W-1:0]   mem_l [0:BUFFER_DEPTH-1];
    logic [SMP_W-1:0]   mem_r [0:BUFFER_DEPTH-1];
    logic [ADDR_W-1:0]  r_wr_idx;
    logic               r_wrapped;
    logic [PHASE_W-1:0] r_phase;

    // Per-word working registers.
    logic signed [SMP_W-1:0]  r_xl;
    logic signed [SMP_W-1:0]  r_xr;
    logic signed [SMP_W-1:0]  r_sine;
    logic [ADDR_W-1:0]        r_rd_idx;
    logic                     r_rd_valid;
    logic [SMP_W-1:0]         r_mem_l;
    logic [SMP_W-1:0]         r_mem_r;
    logic                     r_held_valid;
    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;
    logic                     r_out_valid;
    logic signed [SMP_W-1:0]  r_out_l;
    logic signed [SMP_W-1:0]  r_out_r;

    // Combinational intermediates.
    logic [SINE_IDX_W-1:0]    sin_idx;
    logic [QTR_W:0]           qtr_idx;
    logic signed [SMP_W-1:0]  sin_mag;
    logic signed [NUM_W-1:0]  dly_num;
    logic [DLY_Q_W-1:0]       dly_q;
    logic [ADDR_W-1:0]        dly_val;
    logic [ADDR_W-1:0]        rd_idx;
    logic signed [SMP_W-1:0]  held_l;
    logic signed [SMP_W-1:0]  held_r;
    logic signed [SMP_W:0]    gain_s;

    // Dry sample plus scaled echo, truncated toward zero and saturated.
    function automatic logic signed [SMP_W-1:0] f_mix(
        input logic signed [SMP_W-1:0]  x,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] q;
        logic signed [SMP_W-1:0] res;
        sum = (SUM_W'(x) <<< FRAC_W) + SUM_W'(prod);
        if (sum < 0) begin
            q = (sum + SUM_W'((1 << FRAC_W) - 1)) >>> FRAC_W;
        end else begin
            q = sum >>> FRAC_W;
        end
        if (q > SUM_W'(2 ** (SMP_W - 1) - 1)) begin
            res = {1'b0, {(SMP_W - 1){1'b1}}};
        end else if (q < -SUM_W'(2 ** (SMP_W - 1))) begin
            res = {1'b1, {(SMP_W - 1){1'b0}}};
        end else begin
            res = q[SMP_W-1:0];
        end
        return res;
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= MEAN_RST;
            r_swing <= SWING_RST;
            r_step  <= STEP_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MEAN_DELAY:  r_mean  <= i_cfg_data[MEAN_W-1:0];
                CFG_DELAY_SWING: r_swing <= i_cfg_data[SWING_W-1:0];
                CFG_PHASE_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                CFG_MIX_GAIN:    r_gain  <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Write pointer, fill tracking and LFO phase advance on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx  <= '0;
            r_wrapped <= 1'b0;
            r_phase   <= '0;
        end else if (i_cmd.accept) begin
            r_wr_idx <= r_wr_idx + ADDR_W'(1);
            r_phase  <= r_phase + r_step;
            if (r_wr_idx == ADDR_W'(BUFFER_DEPTH - 1)) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    // Delay stores: written on accept, read in the read step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem_l[r_wr_idx] <= i_left_in;
            mem_r[r_wr_idx] <= i_right_in;
        end
        if (i_cmd.rd_en) begin
            r_mem_l <= mem_l[r_rd_idx];
            r_mem_r <= mem_r[r_rd_idx];
        end
    end

    // Sine lookup: fold the full-cycle index onto the quarter table.
    assign sin_idx = r_phase[PHASE_W-1 -: SINE_IDX_W];
    assign qtr_idx = sin_idx[SINE_IDX_W-2]
                   ? (QTR_W + 1)'(QTR_DEPTH) - {1'b0, sin_idx[QTR_W-1:0]}
                   : {1'b0, sin_idx[QTR_W-1:0]};
    assign sin_mag = signed'(SMP_W'(QSINE_TAB[qtr_idx]));

    // Delay from centre plus swing times sine, clamped to the store.
    assign dly_num = (NUM_W'(r_mean) <<< FRAC_W)
                   + NUM_W'(signed'({1'b0, r_swing}) * r_sine);
    assign dly_q   = dly_num[NUM_W-2:FRAC_W];

    always_comb begin
        if (dly_num <= 0 || dly_q == '0) begin
            dly_val = ADDR_W'(1);
        end else if (32'(dly_q) > 32'(BUFFER_DEPTH - 1)) begin
            dly_val = ADDR_W'(BUFFER_DEPTH - 1);
        end else begin
            dly_val = ADDR_W'(dly_q);
        end
    end

    assign rd_idx = r_wr_idx - dly_val;

    // Entries never written since reset read as zero.
    assign held_l = r_held_valid ? signed'(r_mem_l) : '0;
    assign held_r = r_held_valid ? signed'(r_mem_r) : '0;
    assign gain_s = signed'({1'b0, r_gain});

    // Working registers of the sequenced steps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_xl <= i_left_in;
            r_xr <= i_right_in;
        end
        if (i_cmd.sine_en) begin
            r_sine <= sin_idx[SINE_IDX_W-1] ? -sin_mag : sin_mag;
        end
        if (i_cmd.dly_en) begin
            r_rd_idx   <= rd_idx;
            r_rd_valid <= r_wrapped || (rd_idx < r_wr_idx);
        end
        if (i_cmd.rd_en) begin
            r_held_valid <= r_rd_valid;
        end
        if (i_cmd.prod_en) begin
            r_prod_l <= PROD_W'(held_l * gain_s);
            r_prod_r <= PROD_W'(held_r * gain_s);
        end
        if (i_cmd.out_load) begin
            r_out_l <= f_mix(r_xl, r_prod_l);
            r_out_r <= f_mix(r_xr, r_prod_r);
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_left_out      = r_out_l;
    assign o_right_out     = r_out_r;

    // The read slot is never the slot the next word will overwrite.
    `SF_ASSERT_RST(a_rd_not_wr, i_clk, i_rst_n, i_cmd.rd_en |-> (r_rd_idx != r_wr_idx), "read slot equals next write slot")
    // The write pointer steps by one per accepted word.
    `SF_ASSERT_RST(a_wr_step, i_clk, i_rst_n, i_cmd.accept |=> (r_wr_idx == $past(r_wr_idx) + ADDR_W'(1)), "write pointer did not advance")
    // Once the store has filled, it stays filled until reset.
    `SF_ASSERT_RST(a_wrap_hold, i_clk, i_rst_n, r_wrapped |=> r_wrapped, "fill flag dropped")
    // A new result is never loaded over one the receiver has not taken.
    `SF_ASSERT_ALW(a_no_overrun, i_clk, (i_rst_n && i_cmd.out_load) |-> !(r_out_valid && !i_out_ready), "output overrun")

endmodule

// ===== rtl/core/stereo_flanger.sv =====
`timescale 1ns / 1ps

// Stereo flanger: modulated-delay comb filter on one stereo sample pair per word.
// Input channel i_smp carries left_in/right_in, output channel o_smp carries
// left_out/right_out; both use a valid/ready handshake, a word moves when both
// are high at a rising clock edge. Registers are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write them only while the block is idle,
// which the block itself does not enforce. Each word is processed by a six-state
// sequencer: accept, sine lookup, delay calculation, delay-store read, echo
// multiply, mix and saturate. The result is loaded into the output register in
// the mix step, and a new word is accepted only after that load, once the
// sequencer has returned to idle; each delay store has a single read port.
// Reset (synchronous, active low) returns the registers to their defaults and
// zeroes the write pointer and LFO phase; store entries not yet written since
// reset read as zero, tracked by the write pointer and a fill flag, so no
// clearing pass is needed.
// If the receiver stalls, the result stays in the output register; the block
// still accepts the next word and holds it in the mix step until the pending
// result is taken.
module stereo_flanger (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sf_in_if.sink                         i_smp,
    sf_out_if.source                      o_smp,
    input  logic                          i_cfg_we,
    input  logic [sf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sf_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    // Sequencer.
    sf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Delay stores, LFO and arithmetic.
    sf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_left_in   (i_smp.left_in),
        .i_right_in  (i_smp.right_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_smp.ready),
        .o_out_valid (o_smp.valid),
        .o_left_out  (o_smp.left_out),
        .o_right_out (o_smp.right_out)
    );

    assign i_smp.ready = in_ready;

endmodule
